@@ rtl/core/cdsdl_pkg.sv @@
// shared types, constants and codes of the depth-sorted draw list
package cdsdl_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int QDEPTH   = 2;
  localparam int QP_W     = $clog2(QDEPTH);
  localparam int QC_W     = $clog2(QDEPTH + 1);

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_CULLED   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DRAINED  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // input function codes
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_DRAIN  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_VIEW_X      = 2'd0;
  localparam logic [1:0] REG_VIEW_Y      = 2'd1;
  localparam logic [1:0] REG_VIEW_WIDTH  = 2'd2;
  localparam logic [1:0] REG_VIEW_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    K_INSERT,
    K_CULLED,
    K_DRAIN
  } kind_e;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [11:0]        vw;
    logic [11:0]        vh;
  } view_t;

  typedef struct packed {
    logic signed [15:0] layer;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        id;
    logic               rel;
  } entry_t;

  typedef struct packed {
    kind_e  kind;
    entry_t ent;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             draining;
  } bk_status_t;

endpackage

@@ rtl/core/culled_depth_sorted_draw_list.sv @@
// top level of the culled, depth-sorted sprite draw list
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: func; tdata: sprite fields
//  m_axis    out  tvalid/tready          tuser: status; tdata: handle, screen x/y; tlast
//  cfg       in   cfg_we_i               cfg_idx_i selects view x, y, width, height
//
// an insert or a culled sprite gives one result from the list engine; a drain
// of n entries pops the cell row into the output register one entry at a time,
// and an empty drain gives a single empty result.
// reset empties the list and the queue and loads the default 640x480 view at 0,0.
// the two-entry queue lets the culling front end keep taking transfers while
// the engine drains or the output is stalled.
module culled_depth_sorted_draw_list import cdsdl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] handle, [31:16] pos_x, [47:32] pos_y, [59:48] size_w,
  // [71:60] size_h, [87:72] layer, [88] camera_relative, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] out_handle, [32:16] screen_x, [49:33] screen_y, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i
);

  view_t      view_q;
  logic       push, push_ready, q_valid, q_pop;
  cmd_t       front_cmd, q_cmd;
  bk_status_t bk_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q.vx <= '0;
      view_q.vy <= '0;
      view_q.vw <= 12'd640;
      view_q.vh <= 12'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VIEW_X:      view_q.vx <= cfg_data_i;
        REG_VIEW_Y:      view_q.vy <= cfg_data_i;
        REG_VIEW_WIDTH:  view_q.vw <= cfg_data_i[11:0];
        REG_VIEW_HEIGHT: view_q.vh <= cfg_data_i[11:0];
        default: begin
          view_q <= view_q;
        end
      endcase
    end
  end

  cdsdl_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .view_i        (view_q),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .cmd_o         (front_cmd)
  );

  cdsdl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (push_ready),
    .cmd_i   (front_cmd),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  cdsdl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .view_i        (view_q),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .status_o      (bk_status)
  );

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.draining |-> bk_status.count != '0)
    else $error("drain running on an empty list");

  a_push_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> q_valid)
    else $error("accepted transfer missing from queue");

  a_no_pop_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.draining |-> !q_pop)
    else $error("queue popped during a drain");

endmodule

@@ rtl/core/cdsdl_front.sv @@
// front end: unpacks an input item and runs the view culling test
module cdsdl_front import cdsdl_pkg::*; (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,
  input  view_t                view_i,
  output logic                 push_o,
  input  logic                 push_ready_i,
  output cmd_t                 cmd_o
);

  logic signed [15:0] px, py;
  logic [11:0]        sw, sh;
  logic signed [17:0] px_e, py_e, vx_e, vy_e, right, bottom, px_end, py_end;
  logic               rel, culled;

  assign px  = s_axis_tdata[31:16];
  assign py  = s_axis_tdata[47:32];
  assign sw  = s_axis_tdata[59:48];
  assign sh  = s_axis_tdata[71:60];
  assign rel = s_axis_tdata[88];

  always_comb begin
    px_e   = 18'(px);
    py_e   = 18'(py);
    vx_e   = 18'(view_i.vx);
    vy_e   = 18'(view_i.vy);
    right  = vx_e + $signed({6'b0, view_i.vw});
    bottom = vy_e + $signed({6'b0, view_i.vh});
    px_end = px_e + $signed({6'b0, sw});
    py_end = py_e + $signed({6'b0, sh});
    culled = rel && ((px_e > right) || (py_e > bottom) ||
                     (px_end < vx_e) || (py_end < vy_e));
  end

  always_comb begin
    cmd_o.ent.id    = s_axis_tdata[15:0];
    cmd_o.ent.x     = px;
    cmd_o.ent.y     = py;
    cmd_o.ent.layer = s_axis_tdata[87:72];
    cmd_o.ent.rel   = rel;
    if (s_axis_tuser[0] == FN_DRAIN) begin
      cmd_o.kind = K_DRAIN;
    end else if (culled) begin
      cmd_o.kind = K_CULLED;
    end else begin
      cmd_o.kind = K_INSERT;
    end
  end

  assign push_o        = s_axis_tvalid;
  assign s_axis_tready = push_ready_i;

endmodule

@@ rtl/core/cdsdl_queue.sv @@
// short command queue between the front end and the list engine
module cdsdl_queue import cdsdl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic ready_o,
  input  cmd_t cmd_i,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t            mem [QDEPTH];
  logic [QP_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != QC_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/core/cdsdl_back.sv @@
// list engine: sorted shifting cell row, drain sequencer and output register
module cdsdl_back import cdsdl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  view_t                 view_i,
  input  logic                  q_valid_i,
  input  cmd_t                  q_cmd_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  output bk_status_t            status_o
);

  entry_t            cell_q [CAPACITY];
  logic [CAPACITY-1:0] at_or_after, prev_after;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              drain_q, drain_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_status_q, out_status_d;
  logic [15:0]       out_handle_q, out_handle_d;
  logic signed [16:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic              out_last_q, out_last_d;
  logic              out_free, do_insert, do_shift_out;
  entry_t            head;

  assign out_free = !out_valid_q || m_axis_tready;
  assign q_pop_o  = q_valid_i && out_free && !drain_q;
  assign head     = cell_q[0];

  // a cell is at or after the insertion point if it is unused or not shallower
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
    assign at_or_after[g] = (CNT_W'(g) >= count_q) ||
                            (q_cmd_i.ent.layer <= cell_q[g].layer);
    if (g == 0) begin : g_first
      assign prev_after[g] = 1'b0;
    end else begin : g_rest
      assign prev_after[g] = at_or_after[g-1];
    end
  end

  always_comb begin
    count_d      = count_q;
    drain_d      = drain_q;
    do_insert    = 1'b0;
    do_shift_out = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_last_d   = out_last_q;
    if (drain_q && out_free) begin
      do_shift_out = 1'b1;
      out_valid_d  = 1'b1;
      out_status_d = ST_DRAINED;
      out_handle_d = head.id;
      out_x_d      = 17'(head.x) - (head.rel ? 17'(view_i.vx) : 17'sd0);
      out_y_d      = 17'(head.y) - (head.rel ? 17'(view_i.vy) : 17'sd0);
      out_last_d   = (count_q == CNT_W'(1));
      count_d      = count_q - 1'b1;
      if (count_q == CNT_W'(1)) begin
        drain_d = 1'b0;
      end
    end else if (q_pop_o) begin
      out_handle_d = '0;
      out_x_d      = '0;
      out_y_d      = '0;
      out_last_d   = 1'b1;
      case (q_cmd_i.kind)
        K_INSERT: begin
          out_valid_d = 1'b1;
          if (count_q == CNT_W'(CAPACITY)) begin
            out_status_d = ST_FULL;
          end else begin
            out_status_d = ST_INSERTED;
            do_insert    = 1'b1;
            count_d      = count_q + 1'b1;
          end
        end
        K_CULLED: begin
          out_valid_d  = 1'b1;
          out_status_d = ST_CULLED;
        end
        K_DRAIN: begin
          if (count_q == '0) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_EMPTY;
          end else begin
            drain_d = 1'b1;
          end
        end
        default: begin
          out_valid_d = out_valid_q && !m_axis_tready;
        end
      endcase
    end
  end

  // each cell keeps, takes the new entry, takes its upper neighbor or pops toward the head
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t up_s, dn_s;
    if (g == 0) begin : g_top
      assign up_s = q_cmd_i.ent;
    end else begin : g_mid
      assign up_s = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign dn_s = cell_q[g];
    end else begin : g_nxt
      assign dn_s = cell_q[g+1];
    end
    always_ff @(posedge clk_i) begin
      if (do_insert && at_or_after[g]) begin
        cell_q[g] <= prev_after[g] ? up_s : q_cmd_i.ent;
      end else if (do_shift_out) begin
        cell_q[g] <= dn_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'b0, out_y_q, out_x_q, out_handle_q};

  assign status_o.count    = count_q;
  assign status_o.draining = drain_q;

endmodule

@@ verif/tb_culled_depth_sorted_draw_list.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the culled, depth-sorted sprite draw list
module tb_culled_depth_sorted_draw_list;
  import cdsdl_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int PHASE_ITEMS   = 62;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;  // longest drain plus margin
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic               func;
    logic [15:0]        handle;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [11:0]        w;
    logic [11:0]        h;
    logic signed [15:0] layer;
    logic               rel;
  } sprite_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        handle;
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic               last;
  } draw_res_t;

  typedef struct {
    sprite_t    spr;
    bit         typed;
    logic [2:0] status;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [1:0]            cfg_idx_i;
  logic [15:0]           cfg_data_i;

  // predictor state
  view_t       view;
  entry_t      draw_list[$];
  draw_res_t   step_res[$];
  draw_res_t   pending_draws[$];

  // directed stimulus table
  dir_row_t    dir_rows[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_req;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  culled_depth_sorted_draw_list u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // works out the results of one accepted item and updates the sorted list
  function automatic void predict_draw(sprite_t s);
    int        vx;
    int        vy;
    int        pos;
    int        i;
    entry_t    e;
    draw_res_t r;
    step_res.delete();
    vx = view.vx;
    vy = view.vy;
    r = '0;
    r.last = 1'b1;
    if (s.func == FN_DRAIN) begin
      if (draw_list.size() == 0) begin
        r.status = ST_EMPTY;
        step_res.insert(step_res.size(), r);
      end else begin
        foreach (draw_list[k]) begin
          e = draw_list[k];
          r.status = ST_DRAINED;
          r.handle = e.id;
          r.sx     = 17'(int'(e.x) - (e.rel ? vx : 0));
          r.sy     = 17'(int'(e.y) - (e.rel ? vy : 0));
          r.last   = (k == draw_list.size() - 1);
          step_res.insert(step_res.size(), r);
        end
        draw_list.delete();
      end
    end else begin
      if (s.rel && (int'(s.px) > vx + int'(view.vw) || int'(s.py) > vy + int'(view.vh) ||
                    int'(s.px) + int'(s.w) < vx || int'(s.py) + int'(s.h) < vy)) begin
        r.status = ST_CULLED;
      end else if (draw_list.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // goes ahead of the first entry at the same depth or deeper
        pos = draw_list.size();
        for (i = 0; i < draw_list.size(); i++) begin
          if (s.layer <= draw_list[i].layer) begin
            pos = i;
            break;
          end
        end
        e.layer = s.layer;
        e.x     = s.px;
        e.y     = s.py;
        e.id    = s.handle;
        e.rel   = s.rel;
        draw_list.insert(pos, e);
        r.status = ST_INSERTED;
      end
      step_res.insert(step_res.size(), r);
    end
  endfunction

  function automatic logic signed [15:0] near_view(logic signed [15:0] org, logic [11:0] span);
    int v;
    v = int'(org) - 80 + int'($urandom_range(int'(span) + 160));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic sprite_t rand_sprite();
    sprite_t s;
    s.func   = FN_INSERT;
    s.handle = 16'($urandom);
    s.rel    = ($urandom_range(99) < 80);
    if ($urandom_range(1) == 1) s.layer = 16'($urandom);
    else s.layer = 16'(int'($urandom_range(8)) - 4);  // crowded depths give ties
    if ($urandom_range(99) < 70) begin
      s.w  = 12'($urandom_range(64));
      s.h  = 12'($urandom_range(64));
      s.px = near_view(view.vx, view.vw);
      s.py = near_view(view.vy, view.vh);
    end else begin
      s.w  = 12'($urandom);
      s.h  = 12'($urandom);
      s.px = 16'($urandom);
      s.py = 16'($urandom);
    end
    return s;
  endfunction

  function automatic dir_row_t row(bit fn, int hd, int px, int py, int w, int h, int lay,
                                   bit rel, bit typed, logic [2:0] st);
    dir_row_t r;
    r.spr.func   = fn;
    r.spr.handle = 16'(hd);
    r.spr.px     = 16'(px);
    r.spr.py     = 16'(py);
    r.spr.w      = 12'(w);
    r.spr.h      = 12'(h);
    r.spr.layer  = 16'(lay);
    r.spr.rel    = rel;
    r.typed      = typed;
    r.status     = st;
    return r;
  endfunction

  function automatic void put_row(dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // called and returns at a falling edge
  task automatic send_item(sprite_t s, bit typed = 1'b0, logic [2:0] status = ST_INSERTED);
    draw_res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, s.rel, s.layer, s.h, s.w, s.py, s.px, s.handle};
    s_axis_tuser  <= s.func;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_draw(s);
    if (typed) begin
      r = '0;
      r.status = status;
      r.last = 1'b1;
      pending_draws.insert(pending_draws.size(), r);
    end else begin
      foreach (step_res[k]) pending_draws.insert(pending_draws.size(), step_res[k]);
    end
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_view(view_t v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_VIEW_X;
    cfg_data_i <= v.vx;
    @(negedge clk_i);
    cfg_idx_i  <= REG_VIEW_Y;
    cfg_data_i <= v.vy;
    @(negedge clk_i);
    cfg_idx_i  <= REG_VIEW_WIDTH;
    cfg_data_i <= 16'(v.vw);
    @(negedge clk_i);
    cfg_idx_i  <= REG_VIEW_HEIGHT;
    cfg_data_i <= 16'(v.vh);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    view = v;
  endtask

  // output side: random back-pressure, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_draws
    draw_res_t got;
    draw_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.handle = m_axis_tdata[15:0];
      got.sx     = m_axis_tdata[32:16];
      got.sy     = m_axis_tdata[49:33];
      got.last   = m_axis_tlast;
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: st=%0d id=%h x=%0d y=%0d last=%b",
                   got.status, got.handle, got.sx, got.sy, got.last);
      end else begin
        want = pending_draws[0];
        pending_draws.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d id=%h x=%0d y=%0d last=%b,",
                     want.status, want.handle, want.sx, want.sy, want.last,
                     " got st=%0d id=%h x=%0d y=%0d last=%b",
                     got.status, got.handle, got.sx, got.sy, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_culled_depth_sorted_draw_list NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    view_t    settings[4];
    sprite_t  s;
    int       n;
    int       items;
    int       ph;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FN_INSERT;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_VIEW_X;
    cfg_data_i    = '0;
    src_idle_pct  = 21;
    snk_idle_pct  = 62;
    hold_req      = 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    view = '{vx: 16'sd0, vy: 16'sd0, vw: 12'd640, vh: 12'd480};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part on the reset view 0,0 640x480
    put_row(row(FN_DRAIN, 'hffff, -1, -1, 4095, 4095, -1, 1, 1, ST_EMPTY));
    // touching the right and bottom edges still counts as visible
    put_row(row(FN_INSERT, 'h0001, 640, 480, 0, 0, 5, 1, 1, ST_INSERTED));
    put_row(row(FN_INSERT, 'h0002, 641, 0, 0, 0, 5, 1, 1, ST_CULLED));
    put_row(row(FN_INSERT, 'h0003, 0, 481, 0, 0, 5, 1, 1, ST_CULLED));
    // far side one short of the left or top edge, then just touching
    put_row(row(FN_INSERT, 'h0004, -10, 0, 9, 0, 5, 1, 1, ST_CULLED));
    put_row(row(FN_INSERT, 'h0005, -10, -20, 10, 20, 5, 1, 1, ST_INSERTED));
    put_row(row(FN_INSERT, 'h0006, 0, -20, 0, 19, 5, 1, 1, ST_CULLED));
    // screen-space sprites are never culled
    put_row(row(FN_INSERT, 'hffff, -32768, 32767, 4095, 4095, -32768, 0, 1,
                ST_INSERTED));
    put_row(row(FN_INSERT, 'h8000, 32767, -32768, 0, 0, 32767, 0, 1, ST_INSERTED));
    put_row(row(FN_INSERT, 'h0007, -32768, -32768, 4095, 4095, 0, 1, 1, ST_CULLED));
    put_row(row(FN_INSERT, 'haaaa, 100, 100, 4095, 4095, -1, 1, 1, ST_INSERTED));
    // third entry on layer 5, drains ahead of the older two
    put_row(row(FN_INSERT, 'h5555, 7, 9, 1, 1, 5, 0, 1, ST_INSERTED));
    put_row(row(FN_DRAIN, 'h0000, 0, 0, 0, 0, 0, 0, 0, ST_DRAINED));
    put_row(row(FN_DRAIN, 'h1234, 1, 2, 3, 4, 5, 1, 1, ST_EMPTY));
    put_row(row(FN_INSERT, 'h1234, 320, 240, 16, 16, 0, 1, 1, ST_INSERTED));
    put_row(row(FN_INSERT, 'h4321, 32767, 32767, 4095, 4095, 32767, 1, 1,
                ST_CULLED));
    put_row(row(FN_DRAIN, 'hffff, -1, -1, 4095, 4095, -1, 1, 0, ST_DRAINED));
    foreach (dir_rows[i]) send_item(dir_rows[i].spr, dir_rows[i].typed, dir_rows[i].status);
    settle();

    settings[0] = '{vx: 16'sh8000, vy: 16'sh8000, vw: 12'd4095, vh: 12'd4095};
    settings[1] = '{vx: 16'sh7fff, vy: 16'sh7fff, vw: 12'd1, vh: 12'd1};
    for (ph = 2; ph < 4; ph++) begin
      settings[ph].vx = 16'($urandom);
      settings[ph].vy = 16'($urandom);
      settings[ph].vw = 12'($urandom_range(4095, 1));
      settings[ph].vh = 12'($urandom_range(4095, 1));
    end

    for (ph = 0; ph < 4; ph++) begin
      set_view(settings[ph]);
      src_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 62 : 0;
      snk_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 21 : 0;
      if (ph == 2) begin
        // output held off while inserts keep coming, so the queue fills and stalls input
        hold_req = 1'b1;
        repeat (30) send_item(rand_sprite());
        s = rand_sprite();
        s.func = FN_DRAIN;
        send_item(s);
      end
      items = 0;
      while (items < PHASE_ITEMS) begin
        // mostly short bursts, some long enough to hit a full list
        n = ($urandom_range(99) < 20) ? $urandom_range(40, 30) : $urandom_range(12);
        repeat (n) begin
          send_item(rand_sprite());
          items++;
        end
        s = rand_sprite();
        s.func = FN_DRAIN;
        send_item(s);
        items++;
        if ($urandom_range(99) < 10) begin
          send_item(s);
          items++;
        end
      end
      settle();
    end

    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("tb_culled_depth_sorted_draw_list OK");
    end else begin
      $display("tb_culled_depth_sorted_draw_list NOT OK");
    end
    $finish;
  end

endmodule
